/* rtl/core/atl_pkg.sv */
package atl_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   localparam int NUM_W    = 24;   // |(raw - low) * 180|
   localparam int DEN_W    = 16;   // |raw_high - raw_low|
   localparam int MAP_W    = 26;   // signed mapped axis value
   localparam int FRAC_W   = 20;
   localparam int VEC_W    = 48;
   localparam int ACC_W    = 26;
   localparam int ANG_W    = 17;

   localparam logic signed [ACC_W-1:0] QUARTER_FIX = ACC_W'(5898240);
   localparam logic signed [ANG_W-1:0] HALF_TURN   = ANG_W'(23040);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(11520);
   localparam logic signed [ANG_W-1:0] FULL_TURN   = ANG_W'(46080);

   typedef enum logic [1:0] {
      CSR_RAW_LOW      = 2'd0,
      CSR_RAW_HIGH     = 2'd1,
      CSR_FRAME_OFFSET = 2'd2
   } atl_csr_type;

   typedef struct packed {
      logic valid;
      logic err;
      logic neg_x;
      logic neg_z;
   } atl_meta_type;

   typedef struct packed {
      logic                    valid;
      logic                    err;
      logic                    bypass;
      logic signed [ANG_W-1:0] bang;
   } atl_side_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] dvd;
   } atl_div_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] cx;
      logic signed [VEC_W-1:0] cy;
      logic signed [ACC_W-1:0] acc;
   } atl_vec_type;

   function automatic logic signed [ACC_W-1:0] atan_fix(input logic [4:0] idx);
      logic signed [ACC_W-1:0] v;
      unique case (idx)
         5'd0:  v = ACC_W'(2949120);
         5'd1:  v = ACC_W'(1740967);
         5'd2:  v = ACC_W'(919879);
         5'd3:  v = ACC_W'(466945);
         5'd4:  v = ACC_W'(234379);
         5'd5:  v = ACC_W'(117304);
         5'd6:  v = ACC_W'(58666);
         5'd7:  v = ACC_W'(29335);
         5'd8:  v = ACC_W'(14668);
         5'd9:  v = ACC_W'(7334);
         5'd10: v = ACC_W'(3667);
         5'd11: v = ACC_W'(1833);
         5'd12: v = ACC_W'(917);
         5'd13: v = ACC_W'(458);
         5'd14: v = ACC_W'(229);
         5'd15: v = ACC_W'(115);
         5'd16: v = ACC_W'(57);
         5'd17: v = ACC_W'(29);
         5'd18: v = ACC_W'(14);
         5'd19: v = ACC_W'(7);
         5'd20: v = ACC_W'(4);
         5'd21: v = ACC_W'(2);
         5'd22: v = ACC_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // one restoring division step: shift in the next dividend bit
   function automatic atl_div_type div_step(input atl_div_type cur,
                                            input logic [DEN_W-1:0] den);
      logic [DEN_W:0] part;
      atl_div_type    nxt;
      part    = {cur.rem, cur.dvd[NUM_W-1]};
      nxt.dvd = {cur.dvd[NUM_W-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
         part       = part - {1'b0, den};
         nxt.dvd[0] = 1'b1;
      end
      nxt.rem = part[DEN_W-1:0];
      return nxt;
   endfunction

endpackage

/* rtl/core/atl_if.sv */
interface atl_req_if;
   logic                       valid;
   logic                       ready;
   logic signed [15:0]         accel_x;
   logic signed [15:0]         accel_z;
   modport source (output valid, output accel_x, output accel_z, input ready);
   modport sink   (input valid, input accel_x, input accel_z, output ready);
endinterface

interface atl_rsp_if;
   logic                       valid;
   logic                       ready;
   logic signed [16:0]         incline;
   logic                       span_error;
   modport source (output valid, output incline, output span_error, input ready);
   modport sink   (input valid, input incline, input span_error, output ready);
endinterface

interface atl_csr_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 index;
   logic [15:0]                data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/atl_divider.sv */
module atl_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  atl_pkg::atl_meta_type     meta_in,
   input  logic [atl_pkg::NUM_W-1:0] num_x,
   input  logic [atl_pkg::NUM_W-1:0] num_z,
   input  logic [atl_pkg::DEN_W-1:0] den,
   output atl_pkg::atl_meta_type     meta_out,
   output logic [atl_pkg::NUM_W-1:0] quo_x,
   output logic [atl_pkg::NUM_W-1:0] quo_z
);
   import atl_pkg::*;

   atl_meta_type meta_ff [NUM_W];
   atl_div_type  x_ff    [NUM_W];
   atl_div_type  z_ff    [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      atl_meta_type src_meta;
      atl_div_type  src_x;
      atl_div_type  src_z;
      atl_div_type  x_in;
      atl_div_type  z_in;

      if (s == 0) begin : g_head
         assign src_meta = meta_in;
         assign src_x    = '{rem: '0, dvd: num_x};
         assign src_z    = '{rem: '0, dvd: num_z};
      end else begin : g_body
         assign src_meta = meta_ff[s-1];
         assign src_x    = x_ff[s-1];
         assign src_z    = z_ff[s-1];
      end

      assign x_in = div_step(src_x, den);
      assign z_in = div_step(src_z, den);

      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[s] <= '0;
         end else if (adv) begin
            meta_ff[s] <= src_meta;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[s] <= x_in;
            z_ff[s] <= z_in;
         end
      end
   end

   assign meta_out = meta_ff[NUM_W-1];
   assign quo_x    = x_ff[NUM_W-1].dvd;
   assign quo_z    = z_ff[NUM_W-1].dvd;

endmodule

/* rtl/core/atl_cordic.sv */
module atl_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  atl_pkg::atl_side_type            side_in,
   input  atl_pkg::atl_vec_type             vec_in,
   output atl_pkg::atl_side_type            side_out,
   output logic signed [atl_pkg::ACC_W-1:0] acc_out
);
   import atl_pkg::*;

   atl_side_type side_ff [CORDIC_RUN];
   atl_vec_type  vec_ff  [CORDIC_RUN];

   for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_step
      atl_side_type src_side;
      atl_vec_type  src;
      atl_vec_type  vec_in_i;
      logic signed [VEC_W-1:0] sx;
      logic signed [VEC_W-1:0] sy;
      logic signed [ACC_W-1:0] ang;

      if (i == 0) begin : g_head
         assign src_side = side_in;
         assign src      = vec_in;
      end else begin : g_body
         assign src_side = side_ff[i-1];
         assign src      = vec_ff[i-1];
      end

      assign sx  = src.cx >>> i;
      assign sy  = src.cy >>> i;
      assign ang = atan_fix(5'(i));

      // rotate toward the x axis, steer by the sign of y
      always_comb begin
         if (src.cy > 0) begin
            vec_in_i.cx  = src.cx + sy;
            vec_in_i.cy  = src.cy - sx;
            vec_in_i.acc = src.acc + ang;
         end else begin
            vec_in_i.cx  = src.cx - sy;
            vec_in_i.cy  = src.cy + sx;
            vec_in_i.acc = src.acc - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else if (adv) begin
            side_ff[i] <= src_side;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            vec_ff[i] <= vec_in_i;
         end
      end
   end

   assign side_out = side_ff[CORDIC_RUN-1];
   assign acc_out  = vec_ff[CORDIC_RUN-1].acc;

endmodule

/* rtl/core/accel_tilt_angle.sv */
// Pipeline: 1 map stage, 24 divider stages, 1 setup stage, 16 CORDIC stages and
//    1 output stage lie between an accepted req beat and its rsp beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output
//    register is full and rsp is not ready.
// Reset: synchronous, active high; clears all stage valid bits and loads
//    raw_low = 265, raw_high = 402, frame_offset = 0.
module accel_tilt_angle (
   input  logic  clock,
   input  logic  reset,
   atl_req_if.sink   req_if,
   atl_rsp_if.source rsp_if,
   atl_csr_if.sink   csr_if
);
   import atl_pkg::*;

   // configuration registers
   logic signed [15:0] raw_low_ff;
   logic signed [15:0] raw_high_ff;
   logic signed [15:0] frame_offset_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_low_ff      <= 16'sd265;
         raw_high_ff     <= 16'sd402;
         frame_offset_ff <= 16'sd0;
      end else if (csr_if.valid) begin
         case (atl_csr_type'(csr_if.index))
            CSR_RAW_LOW:      raw_low_ff      <= csr_if.data;
            CSR_RAW_HIGH:     raw_high_ff     <= csr_if.data;
            CSR_FRAME_OFFSET: frame_offset_ff <= csr_if.data;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // one advance for every stage: hold everything while the result waits
   logic out_valid_ff;
   logic adv;

   assign adv          = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // stage A: offset the samples and scale by 180
   logic                    a_valid_ff;
   logic                    a_err_ff;
   logic signed [24:0]      a_num_x_ff;
   logic signed [24:0]      a_num_z_ff;
   logic signed [16:0]      a_span_ff;
   logic signed [16:0]      dx;
   logic signed [16:0]      dz;
   logic signed [16:0]      span_in;
   logic signed [24:0]      num_x_in;
   logic signed [24:0]      num_z_in;

   assign dx       = {req_if.accel_x[15], req_if.accel_x} - {raw_low_ff[15], raw_low_ff};
   assign dz       = {req_if.accel_z[15], req_if.accel_z} - {raw_low_ff[15], raw_low_ff};
   assign span_in  = {raw_high_ff[15], raw_high_ff} - {raw_low_ff[15], raw_low_ff};
   assign num_x_in = 25'(dx) * 25'sd180;
   assign num_z_in = 25'(dz) * 25'sd180;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_err_ff   <= (span_in == 17'sd0);
         a_num_x_ff <= num_x_in;
         a_num_z_ff <= num_z_in;
         a_span_ff  <= span_in;
      end
   end

   // divider works on magnitudes; the quotient sign is the xor of signs
   logic signed [24:0] abs_num_x;
   logic signed [24:0] abs_num_z;
   logic signed [16:0] abs_span;
   atl_meta_type       div_meta_in;
   atl_meta_type       div_meta_out;
   logic [NUM_W-1:0]   quo_x;
   logic [NUM_W-1:0]   quo_z;

   assign abs_num_x = a_num_x_ff[24] ? -a_num_x_ff : a_num_x_ff;
   assign abs_num_z = a_num_z_ff[24] ? -a_num_z_ff : a_num_z_ff;
   assign abs_span  = a_span_ff[16] ? -a_span_ff : a_span_ff;

   assign div_meta_in = '{valid: a_valid_ff,
                          err:   a_err_ff,
                          neg_x: a_num_x_ff[24] ^ a_span_ff[16],
                          neg_z: a_num_z_ff[24] ^ a_span_ff[16]};

   atl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .meta_in  (div_meta_in),
      .num_x    (abs_num_x[NUM_W-1:0]),
      .num_z    (abs_num_z[NUM_W-1:0]),
      .den      (abs_span[DEN_W-1:0]),
      .meta_out (div_meta_out),
      .quo_x    (quo_x),
      .quo_z    (quo_z)
   );

   // stage C: restore signs, subtract 90, pick the exact axis cases and
   // rotate the vector into the right half plane for the CORDIC
   logic signed [MAP_W-1:0] mx;
   logic signed [MAP_W-1:0] mz;
   logic signed [MAP_W-1:0] qx_s;
   logic signed [MAP_W-1:0] qz_s;
   logic signed [VEC_W-1:0] vx;
   logic signed [VEC_W-1:0] vy;
   atl_side_type            c_side_in;
   atl_vec_type             c_vec_in;
   atl_side_type            c_side_ff;
   atl_vec_type             c_vec_ff;

   assign qx_s = {2'b00, quo_x};
   assign qz_s = {2'b00, quo_z};
   assign mx   = (div_meta_out.neg_x ? -qx_s : qx_s) - MAP_W'(90);
   assign mz   = (div_meta_out.neg_z ? -qz_s : qz_s) - MAP_W'(90);

   // the angle is taken of (x = mz, y = mx)
   assign vx = {{(VEC_W-MAP_W-FRAC_W){mz[MAP_W-1]}}, mz, {FRAC_W{1'b0}}};
   assign vy = {{(VEC_W-MAP_W-FRAC_W){mx[MAP_W-1]}}, mx, {FRAC_W{1'b0}}};

   always_comb begin
      c_side_in.valid  = div_meta_out.valid;
      c_side_in.err    = div_meta_out.err;
      c_side_in.bypass = 1'b1;
      if (mx == '0) begin
         // on the x axis, both zero falls here too and reads 180
         c_side_in.bang = (mz > 0) ? '0 : HALF_TURN;
      end else if (mz == '0) begin
         c_side_in.bang = (mx > 0) ? QUARTER_TURN : -QUARTER_TURN;
      end else begin
         c_side_in.bypass = 1'b0;
         c_side_in.bang   = '0;
      end

      if (!mx[MAP_W-1]) begin
         c_vec_in.cx  = vy;
         c_vec_in.cy  = -vx;
         c_vec_in.acc = QUARTER_FIX;
      end else begin
         c_vec_in.cx  = -vy;
         c_vec_in.cy  = vx;
         c_vec_in.acc = -QUARTER_FIX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_side_ff <= '0;
      end else if (adv) begin
         c_side_ff <= c_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_vec_ff <= c_vec_in;
      end
   end

   atl_side_type            cor_side;
   logic signed [ACC_W-1:0] cor_acc;

   atl_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .side_in  (c_side_ff),
      .vec_in   (c_vec_ff),
      .side_out (cor_side),
      .acc_out  (cor_acc)
   );

   // output stage: round to 1/128 degree, fold into (-180, 180], negate and
   // take off the frame offset
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [ANG_W-1:0] ang_raw;
   logic signed [ANG_W-1:0] ang_wrap;
   logic signed [ANG_W-1:0] ang;
   logic signed [ANG_W:0]   res;
   logic signed [16:0]      incline_ff;
   logic                    span_error_ff;

   assign acc_rnd = cor_acc + ACC_W'(256);
   assign ang_raw = acc_rnd[ACC_W-1:9];

   always_comb begin
      ang_wrap = ang_raw;
      if (ang_raw > HALF_TURN) begin
         ang_wrap = ang_raw - FULL_TURN;
      end else if (ang_raw <= -HALF_TURN) begin
         ang_wrap = ang_raw + FULL_TURN;
      end
   end

   assign ang = cor_side.bypass ? cor_side.bang : ang_wrap;
   assign res = -{ang[ANG_W-1], ang}
                - {{(ANG_W+1-16){frame_offset_ff[15]}}, frame_offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cor_side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         incline_ff    <= cor_side.err ? '0 : res[16:0];
         span_error_ff <= cor_side.err;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.incline    = incline_ff;
   assign rsp_if.span_error = span_error_ff;

endmodule

/* sim/tb_accel_tilt_angle.sv */
`timescale 1ns / 100ps

module tb_accel_tilt_angle;
   import atl_pkg::*;

   // one expected rsp beat
   typedef struct {
      logic signed [16:0] incline;
      logic               span_error;
   } tilt_result_type;

   // Tilt predictor plus the queue of results still owed by the block.
   class tilt_scoreboard;
      logic signed [15:0] raw_low;
      logic signed [15:0] raw_high;
      logic signed [15:0] frame_offset;
      tilt_result_type    owed[$];
      int                 fails;
      longint             atan_step[32];

      function new();
         longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                           29, 14, 7, 4, 2, 1};
         foreach (atan_step[i]) atan_step[i] = (i < 23) ? t[i] : 0;
         raw_low      = 16'sd265;
         raw_high     = 16'sd402;
         frame_offset = 16'sd0;
         fails        = 0;
      endfunction

      function void set_reg(atl_csr_type idx, logic [15:0] val);
         case (idx)
            CSR_RAW_LOW:      raw_low = val;
            CSR_RAW_HIGH:     raw_high = val;
            CSR_FRAME_OFFSET: frame_offset = val;
            default: ;
         endcase
      endfunction

      // vector angle of (x, y) in 1/128 degree, range (-180, 180]
      function longint vector_angle(longint x, longint y);
         longint cx, cy, acc, nx, a;
         if (y == 0) return (x > 0) ? 0 : 23040;
         if (x == 0) return (y > 0) ? 11520 : -11520;
         x = x * 1048576;
         y = y * 1048576;
         if (y >= 0) begin
            cx = y; cy = -x; acc = 5898240;
         end else begin
            cx = -y; cy = x; acc = -5898240;
         end
         for (int i = 0; i < CORDIC_RUN; i++) begin
            if (cy > 0) begin
               nx  = cx + (cy >>> i);
               cy  = cy - (cx >>> i);
               acc = acc + atan_step[i];
            end else begin
               nx  = cx - (cy >>> i);
               cy  = cy + (cx >>> i);
               acc = acc - atan_step[i];
            end
            cx = nx;
         end
         a = (acc + 256) >>> 9;
         if (a > 23040) a = a - 46080;
         if (a <= -23040) a = a + 46080;
         return a;
      endfunction

      function void note_sample(logic signed [15:0] ax, logic signed [15:0] az);
         tilt_result_type r;
         longint          lo, span, mx, mz, ang, res;
         lo = raw_low;
         if (raw_high == raw_low) begin
            r.incline    = '0;
            r.span_error = 1'b1;
         end else begin
            span = longint'(raw_high) - lo;
            mx   = (longint'(ax) - lo) * 180 / span - 90;
            mz   = (longint'(az) - lo) * 180 / span - 90;
            ang  = (mx == 0 && mz == 0) ? 23040 : vector_angle(mz, mx);
            res  = -ang - longint'(frame_offset);
            r.incline    = res[16:0];
            r.span_error = 1'b0;
         end
         owed.push_back(r);
      endfunction

      function void check_result(logic signed [16:0] inc, logic err);
         tilt_result_type e;
         if (owed.size() == 0) begin
            $error("rsp beat with nothing owed: incline=%0d span_error=%0b", inc, err);
            fails++;
            return;
         end
         e = owed.pop_front();
         if (inc !== e.incline) begin
            $error("incline: expected %0d, got %0d", e.incline, inc);
            fails++;
         end
         if (err !== e.span_error) begin
            $error("span_error: expected %0b, got %0b", e.span_error, err);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_rsp = 1'b0;   // ask the rsp side for one long hold-off

   atl_req_if req_if ();
   atl_rsp_if rsp_if ();
   atl_csr_if csr_if ();

   tilt_scoreboard sb = new();

   accel_tilt_angle u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Drive one req beat; hold it until accepted, then note it.
   task automatic send_sample(logic [15:0] ax, logic [15:0] az);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.accel_x <= ax;
      req_if.accel_z <= az;
      do @(posedge clock); while (!req_if.ready);
      sb.note_sample(ax, az);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_reg(atl_csr_type idx, logic [15:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drain the pipeline, then let the latency pass before touching registers.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic set_span(logic [15:0] lo, logic [15:0] hi, logic [15:0] off);
      drain();
      write_reg(CSR_RAW_LOW, lo);
      write_reg(CSR_RAW_HIGH, hi);
      write_reg(CSR_FRAME_OFFSET, off);
   endtask

   // Random sample: mostly near the span so the angle sweeps every quadrant,
   // some anywhere in the 16 bit range.
   function automatic logic [15:0] pick_raw();
      int lo, hi, w;
      lo = (sb.raw_low < sb.raw_high) ? sb.raw_low : sb.raw_high;
      hi = (sb.raw_low < sb.raw_high) ? sb.raw_high : sb.raw_low;
      w  = hi - lo;
      if ($urandom_range(0, 3) == 0) return 16'($urandom());
      lo = lo - w / 4;
      hi = hi + w / 4;
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return 16'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   task automatic random_burst(int n);
      repeat (n) send_sample(pick_raw(), pick_raw());
   endtask

   // rsp side: random ready with stretches of no stall; one long hold on request.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         if (pick_gap() > 0 && !hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (pick_gap() + 1) @(negedge clock);
         end
      end
   end

   // Sample rsp beats at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.incline, rsp_if.span_error);
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.accel_x = '0;
      req_if.accel_z = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_RAW_LOW;
      csr_if.data    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats at reset span 265..402: field extremes, the span edges,
      // both mapped zero (raw 334 maps to 0), and axis-aligned vectors.
      send_sample(16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff);
      send_sample(16'h8000, 16'h7fff);
      send_sample(16'h7fff, 16'h8000);
      send_sample(16'hffff, 16'h0000);
      send_sample(16'd265, 16'd402);
      send_sample(16'd402, 16'd265);
      send_sample(16'd334, 16'd334);
      send_sample(16'd334, 16'd402);
      send_sample(16'd334, 16'd265);
      send_sample(16'd402, 16'd334);
      send_sample(16'd265, 16'd334);
      send_sample(16'd265, 16'd265);
      send_sample(16'd402, 16'd402);
      send_sample(16'h5555, 16'haaaa);
      send_sample(16'haaaa, 16'h5555);

      // Long rsp hold while req keeps offering beats: fill the pipe and stall req.
      hold_rsp = 1'b1;
      random_burst(150);

      // Widest span with the largest offset.
      set_span(16'h8000, 16'h7fff, 16'sd23040);
      send_sample(16'h0000, 16'h0000);
      send_sample(16'hffff, 16'hffff);
      random_burst(140);

      // Reversed span, negative offset.
      set_span(16'h7fff, 16'h8000, -16'sd23040);
      random_burst(140);

      // Equal span: every beat flags the error.
      set_span(16'sd100, 16'sd100, 16'sd77);
      send_sample(16'sd100, 16'sd100);
      random_burst(40);

      // Unit span: mapped values far outside +-90; offset beyond its range.
      set_span(16'sd0, 16'sd1, 16'h7fff);
      send_sample(16'h7fff, 16'h8000);
      random_burst(120);
      set_span(16'sd0, 16'sd1, 16'h8000);
      random_burst(80);

      // Random settings for the rest.
      repeat (5) begin
         set_span(16'($urandom()), 16'($urandom()),
                  16'($signed($urandom_range(0, 46080)) - 23040));
         random_burst(90);
      end

      drain();
      if (sb.fails == 0 && sb.owed.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
